[rtl/assert_macros.svh]
// assertion macros used by the checker file tlb_checker.sv
// no dependencies; included by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define TLB_ASSERT_PROP(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition that must never be seen outside reset
`define TLB_ASSERT_NEVER(label, clk, rst, cond, msg) \
   `TLB_ASSERT_PROP(label, clk, rst, !(cond), msg)

`endif

[rtl/tlb_pkg.sv]
// types, constants and codes of the text terminal line buffer
// no dependencies
package tlb_pkg;

   // screen geometry
   localparam int SCREEN_ROWS = 4;
   localparam int LINE_CHARS  = 21;
   localparam int CELLS       = SCREEN_ROWS * LINE_CHARS;
   localparam int ROW_W       = (SCREEN_ROWS > 1) ? $clog2(SCREEN_ROWS) : 1;
   localparam int COL_W       = $clog2(LINE_CHARS);
   localparam int ADDR_W      = $clog2(CELLS);

   localparam logic [COL_W-1:0] LAST_COL = COL_W'(LINE_CHARS - 1);
   localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(SCREEN_ROWS - 1);

   // transaction kinds
   localparam logic [1:0] KIND_PUT   = 2'd0;
   localparam logic [1:0] KIND_CLEAR = 2'd1;
   localparam logic [1:0] KIND_READ  = 2'd2;

   // special bytes
   localparam logic [7:0] CH_NUL = 8'd0;
   localparam logic [7:0] CH_LF  = 8'd10;
   localparam logic [7:0] CH_CR  = 8'd13;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_BLANK,
      ST_WRITE,
      ST_ADVANCE,
      ST_COPY_RD,
      ST_COPY_WR,
      ST_SCROLL_END,
      ST_TAIL,
      ST_READ,
      ST_READ_DATA,
      ST_RESP
   } state_type;

   // command from the sequencer to the cell store
   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        wdata;
      logic              set_valid;
      logic              clr_valid;
      logic [ROW_W-1:0]  vrow;
      logic              clr_all;
   } store_cmd_type;

endpackage

[rtl/tlb_if.sv]
// valid/ready channel interfaces for request and response transactions
// no dependencies

interface tlb_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] char_code;
   logic [1:0] read_row;
   logic [4:0] read_col;

   modport source (output valid, kind, char_code, read_row, read_col, input ready);
   modport sink   (input valid, kind, char_code, read_row, read_col, output ready);
endinterface

interface tlb_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] cell_value;
   logic [4:0] cursor_column;
   logic [1:0] cursor_line;

   modport source (output valid, cell_value, cursor_column, cursor_line, input ready);
   modport sink   (input valid, cell_value, cursor_column, cursor_line, output ready);
endinterface

[rtl/tlb_cell_store.sv]
// cell memory of the screen with one row valid bit per row
// depends on tlb_pkg
module tlb_cell_store (
   input  logic                                 clock,
   input  logic                                 reset,
   input  tlb_pkg::store_cmd_type               cmd,
   output logic [7:0]                           rdata,
   output logic [tlb_pkg::SCREEN_ROWS-1:0]      row_valid
);

   logic [7:0]                      mem [tlb_pkg::CELLS];
   logic [7:0]                      rdata_ff;
   logic [tlb_pkg::SCREEN_ROWS-1:0] row_valid_ff;
   logic [tlb_pkg::SCREEN_ROWS-1:0] row_valid_in;

   // single address port, registered read
   always_ff @(posedge clock) begin
      if (cmd.we) begin
         mem[cmd.addr] <= cmd.wdata;
      end
      rdata_ff <= mem[cmd.addr];
   end

   // row valid bits; the sequencer reads a row that is not valid as blank
   always_comb begin
      row_valid_in = row_valid_ff;
      priority if (cmd.clr_all) begin
         row_valid_in = '0;
      end else if (cmd.set_valid) begin
         row_valid_in[cmd.vrow] = 1'b1;
      end else if (cmd.clr_valid) begin
         row_valid_in[cmd.vrow] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
      end else begin
         row_valid_ff <= row_valid_in;
      end
   end

   assign rdata     = rdata_ff;
   assign row_valid = row_valid_ff;

endmodule

[rtl/tlb_seq.sv]
// sequencer with cursor registers and the shared cell address unit
// depends on tlb_pkg and tlb_if
module tlb_seq (
   input  logic                            clock,
   input  logic                            reset,
   tlb_req_if.sink                         req_chan,
   tlb_rsp_if.source                       rsp_chan,
   output tlb_pkg::store_cmd_type          cmd,
   input  logic [7:0]                      rdata,
   input  logic [tlb_pkg::SCREEN_ROWS-1:0] row_valid
);

   tlb_pkg::state_type              state_ff, state_in;
   logic [tlb_pkg::COL_W-1:0]       col_ff, col_in;
   logic [tlb_pkg::ROW_W-1:0]       row_ff, row_in;
   logic [tlb_pkg::COL_W-1:0]       cp_col_ff, cp_col_in;
   logic [tlb_pkg::ROW_W-1:0]       cp_row_ff, cp_row_in;
   logic [7:0]                      cell_ff, cell_in;
   logic [7:0]                      char_ff;
   logic [1:0]                      rrow_ff;
   logic [4:0]                      rcol_ff;
   logic [tlb_pkg::ROW_W-1:0]       addr_row;
   logic [tlb_pkg::COL_W-1:0]       addr_col;
   logic [tlb_pkg::ADDR_W-1:0]      addr_sum;
   logic                            rd_in_range;
   logic                            accept;

   assign accept = req_chan.valid && req_chan.ready;

   // shared address unit: row times line length plus column
   assign addr_sum = tlb_pkg::ADDR_W'(addr_row) * tlb_pkg::ADDR_W'(tlb_pkg::LINE_CHARS)
                   + tlb_pkg::ADDR_W'(addr_col);

   assign rd_in_range = (32'(rrow_ff) < tlb_pkg::SCREEN_ROWS)
                     && (32'(rcol_ff) < tlb_pkg::LINE_CHARS);

   // latch the request payload
   always_ff @(posedge clock) begin
      if (accept) begin
         char_ff <= req_chan.char_code;
         rrow_ff <= req_chan.read_row;
         rcol_ff <= req_chan.read_col;
      end
   end

   // state, cursor and copy counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= tlb_pkg::ST_IDLE;
         col_ff    <= '0;
         row_ff    <= '0;
         cp_col_ff <= '0;
         cp_row_ff <= '0;
      end else begin
         state_ff  <= state_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         cp_col_ff <= cp_col_in;
         cp_row_ff <= cp_row_in;
      end
   end

   always_ff @(posedge clock) begin
      cell_ff <= cell_in;
   end

   // next state and store commands
   always_comb begin
      state_in      = state_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      cp_col_in     = cp_col_ff;
      cp_row_in     = cp_row_ff;
      cell_in       = cell_ff;
      addr_row      = row_ff;
      addr_col      = col_ff;
      cmd           = '0;
      unique case (state_ff)
         tlb_pkg::ST_IDLE: begin
            if (req_chan.valid) begin
               cell_in = '0;
               priority if (req_chan.kind == tlb_pkg::KIND_CLEAR) begin
                  col_in      = '0;
                  row_in      = '0;
                  cmd.clr_all = 1'b1;
                  state_in    = tlb_pkg::ST_RESP;
               end else if (req_chan.kind == tlb_pkg::KIND_READ) begin
                  state_in = tlb_pkg::ST_READ;
               end else if (req_chan.kind == tlb_pkg::KIND_PUT
                            && req_chan.char_code != tlb_pkg::CH_NUL) begin
                  priority if (req_chan.char_code == tlb_pkg::CH_LF
                               || req_chan.char_code == tlb_pkg::CH_CR) begin
                     state_in = tlb_pkg::ST_ADVANCE;
                  end else if (row_valid[row_ff]) begin
                     state_in = tlb_pkg::ST_WRITE;
                  end else begin
                     cp_col_in = '0;
                     state_in  = tlb_pkg::ST_BLANK;
                  end
               end else begin
                  state_in = tlb_pkg::ST_RESP;
               end
            end
         end
         // zero fill of the cursor row before its first write
         tlb_pkg::ST_BLANK: begin
            addr_col  = cp_col_ff;
            cmd.we    = 1'b1;
            cmd.wdata = '0;
            if (cp_col_ff == tlb_pkg::LAST_COL) begin
               cmd.set_valid = 1'b1;
               cmd.vrow      = row_ff;
               state_in      = tlb_pkg::ST_WRITE;
            end else begin
               cp_col_in = cp_col_ff + tlb_pkg::COL_W'(1);
            end
         end
         tlb_pkg::ST_WRITE: begin
            cmd.we    = 1'b1;
            cmd.wdata = char_ff;
            state_in  = tlb_pkg::ST_ADVANCE;
         end
         // column advance, wrap to next line, scroll at bottom
         tlb_pkg::ST_ADVANCE: begin
            if (col_ff == tlb_pkg::LAST_COL || char_ff == tlb_pkg::CH_LF) begin
               col_in = '0;
               if (row_ff == tlb_pkg::LAST_ROW) begin
                  cp_row_in = '0;
                  cp_col_in = '0;
                  state_in  = tlb_pkg::ST_COPY_RD;
               end else begin
                  row_in   = row_ff + tlb_pkg::ROW_W'(1);
                  state_in = tlb_pkg::ST_TAIL;
               end
            end else begin
               col_in   = col_ff + tlb_pkg::COL_W'(1);
               state_in = tlb_pkg::ST_TAIL;
            end
         end
         // scroll: read a cell of the row below
         tlb_pkg::ST_COPY_RD: begin
            addr_row = cp_row_ff + tlb_pkg::ROW_W'(1);
            addr_col = cp_col_ff;
            state_in = tlb_pkg::ST_COPY_WR;
         end
         // scroll: write it one row up
         tlb_pkg::ST_COPY_WR: begin
            addr_row  = cp_row_ff;
            addr_col  = cp_col_ff;
            cmd.we    = 1'b1;
            cmd.wdata = row_valid[cp_row_ff + tlb_pkg::ROW_W'(1)] ? rdata : 8'd0;
            state_in  = tlb_pkg::ST_COPY_RD;
            if (cp_col_ff == tlb_pkg::LAST_COL) begin
               cmd.set_valid = 1'b1;
               cmd.vrow      = cp_row_ff;
               cp_col_in     = '0;
               if (cp_row_ff == tlb_pkg::LAST_ROW - tlb_pkg::ROW_W'(1)) begin
                  state_in = tlb_pkg::ST_SCROLL_END;
               end else begin
                  cp_row_in = cp_row_ff + tlb_pkg::ROW_W'(1);
               end
            end else begin
               cp_col_in = cp_col_ff + tlb_pkg::COL_W'(1);
            end
         end
         tlb_pkg::ST_SCROLL_END: begin
            cmd.clr_valid = 1'b1;
            cmd.vrow      = tlb_pkg::LAST_ROW;
            state_in      = tlb_pkg::ST_TAIL;
         end
         // carriage return homes the column and blanks the row
         tlb_pkg::ST_TAIL: begin
            if (char_ff == tlb_pkg::CH_CR) begin
               col_in        = '0;
               cmd.clr_valid = 1'b1;
               cmd.vrow      = row_ff;
            end
            state_in = tlb_pkg::ST_RESP;
         end
         tlb_pkg::ST_READ: begin
            if (rd_in_range) begin
               addr_row = tlb_pkg::ROW_W'(rrow_ff);
               addr_col = tlb_pkg::COL_W'(rcol_ff);
            end else begin
               addr_row = '0;
               addr_col = '0;
            end
            state_in = tlb_pkg::ST_READ_DATA;
         end
         tlb_pkg::ST_READ_DATA: begin
            if (rd_in_range && row_valid[tlb_pkg::ROW_W'(rrow_ff)]) begin
               cell_in = rdata;
            end else begin
               cell_in = '0;
            end
            state_in = tlb_pkg::ST_RESP;
         end
         tlb_pkg::ST_RESP: begin
            if (rsp_chan.ready) begin
               state_in = tlb_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tlb_pkg::ST_IDLE;
         end
      endcase
      cmd.addr = addr_sum;
   end

   // handshake and response payload
   assign req_chan.ready         = (state_ff == tlb_pkg::ST_IDLE);
   assign rsp_chan.valid         = (state_ff == tlb_pkg::ST_RESP);
   assign rsp_chan.cell_value    = cell_ff;
   assign rsp_chan.cursor_column = 5'(col_ff);
   assign rsp_chan.cursor_line   = 2'(row_ff);

endmodule

[rtl/text_terminal_line_buffer_unit.sv]
// top level of the text terminal line buffer
// depends on tlb_pkg, tlb_if, tlb_cell_store and tlb_seq
//
// Usage: one request transaction on req_chan (kind, char_code, read_row,
// read_col) gives exactly one response on rsp_chan (cell_value, cursor_column,
// cursor_line). Kinds: put a character, clear screen, read one cell.
// The block works on one transaction at a time; req_chan.ready is high only
// while idle. States from accept to rsp_chan.valid by kind:
//   clear, unused kind, put of byte zero: straight to ST_RESP
//   read cell: ST_READ, ST_READ_DATA
//   put of a printable byte: ST_WRITE, ST_ADVANCE, ST_TAIL; line feed or
//   carriage return: ST_ADVANCE, ST_TAIL; a printable byte into a row that is
//   not yet valid first runs ST_BLANK, which zero-fills that row cell by cell;
//   a wrap at the bottom row runs ST_COPY_RD, ST_COPY_WR and ST_SCROLL_END;
//   the single-port cell memory copies every cell one row up, read then write.
// The response is held in an output register until rsp_chan.ready; a new
// request is taken the cycle after the response transaction.
// Reset clears the cursor and the row valid bits, so the screen reads blank
// at once; no clearing pass runs.
module text_terminal_line_buffer_unit (
   input  logic       clock,
   input  logic       reset,
   tlb_req_if.sink    req_chan,
   tlb_rsp_if.source  rsp_chan
);

   tlb_pkg::store_cmd_type          cmd;
   logic [7:0]                      rdata;
   logic [tlb_pkg::SCREEN_ROWS-1:0] row_valid;

   // sequencer and shared address unit
   tlb_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .cmd       (cmd),
      .rdata     (rdata),
      .row_valid (row_valid)
   );

   // screen cell memory
   tlb_cell_store u_store (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .rdata     (rdata),
      .row_valid (row_valid)
   );

endmodule

[rtl/tlb_checker.sv]
// port level checks of the text terminal line buffer, bound to the top level
// depends on tlb_pkg and assert_macros.svh
`include "assert_macros.svh"

module tlb_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [1:0] req_kind,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_cell_value,
   input logic [4:0] rsp_cursor_column,
   input logic [1:0] rsp_cursor_line
);

   // a pending response holds
   `TLB_ASSERT_PROP(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_cell_value) && $stable(rsp_cursor_column), "response changed while stalled")

   // one transaction in flight at a time
   `TLB_ASSERT_NEVER(a_no_overlap, clock, reset, req_ready && rsp_valid, "request taken while response pending")

   `TLB_ASSERT_PROP(a_busy_after_accept, clock, reset, req_valid && req_ready |=> !req_ready, "ready stayed high after accept")

   // clear answers next cycle with home cursor and zero cell
   `TLB_ASSERT_PROP(a_clear_home, clock, reset, req_valid && req_ready && req_kind == tlb_pkg::KIND_CLEAR |=> rsp_valid && rsp_cursor_column == 5'd0 && rsp_cursor_line == 2'd0 && rsp_cell_value == 8'd0, "clear did not home cursor")

   `TLB_ASSERT_PROP(a_col_range, clock, reset, rsp_valid |-> 32'(rsp_cursor_column) < tlb_pkg::LINE_CHARS, "cursor column off screen")

endmodule

bind text_terminal_line_buffer_unit tlb_checker u_tlb_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_chan.valid),
   .req_ready         (req_chan.ready),
   .req_kind          (req_chan.kind),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_cell_value    (rsp_chan.cell_value),
   .rsp_cursor_column (rsp_chan.cursor_column),
   .rsp_cursor_line   (rsp_chan.cursor_line)
);
